// ===== sv/aqlu_pkg.sv =====
// Shared types and constants for the array queue lock unit.
`timescale 1ns / 1ps
`default_nettype none

package aqlu_pkg;

    // Fixed field widths
    localparam int CFG_W     = 7;
    localparam int CMD_W     = 3;
    localparam int LOCK_ID_W = 4;
    localparam int SLOT_IO_W = 6;
    localparam int STATUS_W  = 2;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE = 3'd0,
        CMD_TRY     = 3'd1,
        CMD_RELEASE = 3'd2,
        CMD_POLL    = 3'd3,
        CMD_QUERY   = 3'd4
    } t_cmd;

    // Status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_BUSY  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;   // write reset entry at the clear address
        logic capture;    // take input word, read lock entry
        logic check;      // load tail from entry, arm reduction
        logic mod_step;   // one step of tail reduction
        logic exec;       // update entry, load result word
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_last; // last entry of the clearing pass
        logic tail_stale; // stored tail not below slot count
        logic mod_last;   // reduction finishes this step
        logic out_free;   // output register can take a word
    } t_dp_status;

endpackage

`default_nettype wire

// ===== sv/array_queue_lock_unit.sv =====
// Top level of the array queue lock bank.
//
//  channel   direction  handshake               payload
//  input     in         i_in_valid/o_in_stall   i_command, i_lock_id, i_slot
//  output    out        o_out_valid/i_out_stall o_status, o_result_slot, o_granted
//  config    in         i_cfg_we                i_cfg_wdata (slots_in_use)
//
// A command holds the input through its steps: lock memory read, tail check, then
// read-modify-write of the lock entry and output load; the result word is
// registered, and the next word is taken only after that output load.
// A stored tail not below slots_in_use (after the count shrank) is reduced
// modulo slots_in_use in the shift-subtract remainder unit before use.
// After reset a clearing pass writes every lock entry with the input stalled;
// config writes are taken throughout.
// A held output word holds the entry update until the word is taken.
`timescale 1ns / 1ps
`default_nettype none

module array_queue_lock_unit import aqlu_pkg::*; #(
    parameter int LOCK_COUNT = 16,
    parameter int MAX_SLOTS  = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [CMD_W-1:0]     i_command,
    input  wire logic [LOCK_ID_W-1:0] i_lock_id,
    input  wire logic [SLOT_IO_W-1:0] i_slot,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [STATUS_W-1:0]       o_status,
    output logic [SLOT_IO_W-1:0]      o_result_slot,
    output logic                      o_granted
);

    t_dp_cmd    w_cmd;
    t_dp_status w_stat;

    aqlu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    aqlu_datapath #(
        .LOCK_COUNT (LOCK_COUNT),
        .MAX_SLOTS  (MAX_SLOTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_command     (i_command),
        .i_lock_id     (i_lock_id),
        .i_slot        (i_slot),
        .i_out_stall   (i_out_stall),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_result_slot (o_result_slot),
        .o_granted     (o_granted)
    );

endmodule

`default_nettype wire

// ===== sv/aqlu_datapath.sv =====
// Datapath of the lock unit: lock memory, tail reduction and result register.
`timescale 1ns / 1ps
`default_nettype none

module aqlu_datapath import aqlu_pkg::*; #(
    parameter int LOCK_COUNT = 16,
    parameter int MAX_SLOTS  = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic [CMD_W-1:0]     i_command,
    input  wire logic [LOCK_ID_W-1:0] i_lock_id,
    input  wire logic [SLOT_IO_W-1:0] i_slot,
    input  wire logic                 i_out_stall,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_status                o_stat,
    output logic                      o_out_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic [SLOT_IO_W-1:0]      o_result_slot,
    output logic                      o_granted
);

    localparam int LOCK_W = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int SZ_W   = $clog2(MAX_SLOTS + 1);
    localparam int CNT_W  = $clog2(SLOT_W + 1);
    localparam int WORD_W = SLOT_W + MAX_SLOTS;
    // entry layout {tail, flags}; reset: tail 0, flag 0 set
    localparam logic [WORD_W-1:0] RST_WORD = WORD_W'(1);

    logic [WORD_W-1:0]    r_mem [LOCK_COUNT];
    logic [WORD_W-1:0]    r_rd_word;
    logic [LOCK_W-1:0]    r_clr_addr;
    logic [LOCK_W-1:0]    r_lock;
    logic [CMD_W-1:0]     r_cmd;
    logic [SLOT_IO_W-1:0] r_slot;
    logic [SZ_W-1:0]      r_size;
    logic [SZ_W-1:0]      n_size;
    logic [SLOT_W-1:0]    r_tail;
    logic [SLOT_W-1:0]    r_rem;
    logic [SLOT_W-1:0]    r_sh;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_status;
    logic [SLOT_IO_W-1:0] r_rslot;
    logic                 r_grant;

    logic [LOCK_W-1:0]    w_in_idx;
    logic [SLOT_W-1:0]    w_rd_tail;
    logic [MAX_SLOTS-1:0] w_rd_flags;
    logic [CFG_W-1:0]     w_size7;
    logic [CFG_W-1:0]     w_rem_sh;
    logic [SLOT_W-1:0]    w_rem_nxt;
    logic [CFG_W-1:0]     w_slot7;
    logic [CFG_W-1:0]     w_slot_p1;
    logic [CFG_W-1:0]     w_tail_p1;
    logic                 w_slot_ok;
    logic [SLOT_W-1:0]    w_slot_idx;
    logic [SLOT_W-1:0]    w_nxt;
    logic [SLOT_W-1:0]    w_tail_nxt;
    logic                 w_tail_flag;
    logic [STATUS_W-1:0]  w_status;
    logic [SLOT_IO_W-1:0] w_rslot;
    logic                 w_grant;
    logic [SLOT_W-1:0]    w_wr_tail;
    logic [MAX_SLOTS-1:0] w_wr_flags;

    assign w_in_idx   = LOCK_W'(i_lock_id % LOCK_COUNT);
    assign w_rd_tail  = r_rd_word[WORD_W-1:MAX_SLOTS];
    assign w_rd_flags = r_rd_word[MAX_SLOTS-1:0];
    assign w_size7    = CFG_W'(r_size);

    // Effective slot count: zero acts as one, clamp to MAX_SLOTS
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_size = SZ_W'(1);
        end else if (i_cfg_wdata > CFG_W'(MAX_SLOTS)) begin
            n_size = SZ_W'(MAX_SLOTS);
        end else begin
            n_size = SZ_W'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SZ_W'(MAX_SLOTS);
        end else if (i_cfg_we) begin
            r_size <= n_size;
        end
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr_addr <= r_clr_addr + LOCK_W'(1);
        end
    end

    // Lock memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            r_mem[r_clr_addr] <= RST_WORD;
        end else if (i_cmd.exec) begin
            r_mem[r_lock] <= {w_wr_tail, w_wr_flags};
        end
        if (i_cmd.capture) begin
            r_rd_word <= r_mem[w_in_idx];
        end
    end

    // Input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lock <= w_in_idx;
            r_cmd  <= i_command;
            r_slot <= i_slot;
        end
    end

    // Tail reduction, one remainder bit per step
    assign w_rem_sh  = CFG_W'({r_rem, r_sh[SLOT_W-1]});
    assign w_rem_nxt = SLOT_W'((w_rem_sh >= w_size7) ? (w_rem_sh - w_size7) : w_rem_sh);

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_tail <= w_rd_tail;
            r_sh   <= w_rd_tail;
            r_rem  <= '0;
            r_cnt  <= CNT_W'(SLOT_W);
        end else if (i_cmd.mod_step) begin
            r_rem <= w_rem_nxt;
            r_sh  <= r_sh << 1;
            r_cnt <= r_cnt - CNT_W'(1);
            if (o_stat.mod_last) begin
                r_tail <= w_rem_nxt;
            end
        end
    end

    // Slot arithmetic
    assign w_slot7     = CFG_W'(r_slot);
    assign w_slot_ok   = w_slot7 < w_size7;
    assign w_slot_idx  = r_slot[SLOT_W-1:0];
    assign w_slot_p1   = w_slot7 + CFG_W'(1);
    assign w_nxt       = (w_slot_p1 == w_size7) ? '0 : w_slot_p1[SLOT_W-1:0];
    assign w_tail_p1   = CFG_W'(r_tail) + CFG_W'(1);
    assign w_tail_nxt  = (w_tail_p1 == w_size7) ? '0 : w_tail_p1[SLOT_W-1:0];
    assign w_tail_flag = w_rd_flags[r_tail];

    // Command execution; the stored tail is rewritten only when it advances
    always_comb begin
        w_status   = ST_DONE;
        w_rslot    = '0;
        w_grant    = 1'b0;
        w_wr_tail  = w_rd_tail;
        w_wr_flags = w_rd_flags;
        case (r_cmd)
            CMD_ACQUIRE: begin
                w_rslot   = SLOT_IO_W'(r_tail);
                w_grant   = w_tail_flag;
                w_wr_tail = w_tail_nxt;
            end
            CMD_TRY: begin
                if (w_tail_flag) begin
                    w_rslot   = SLOT_IO_W'(r_tail);
                    w_grant   = 1'b1;
                    w_wr_tail = w_tail_nxt;
                end else begin
                    w_status = ST_BUSY;
                end
            end
            CMD_RELEASE: begin
                if (w_slot_ok) begin
                    w_wr_flags = (w_rd_flags & ~(MAX_SLOTS'(1) << w_slot_idx))
                               | (MAX_SLOTS'(1) << w_nxt);
                    w_rslot    = SLOT_IO_W'(w_nxt);
                    w_grant    = 1'b1;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            CMD_POLL: begin
                if (w_slot_ok) begin
                    w_rslot = r_slot;
                    w_grant = w_rd_flags[w_slot_idx];
                end else begin
                    w_status = ST_RANGE;
                end
            end
            CMD_QUERY: begin
                w_rslot = SLOT_IO_W'(r_tail);
                w_grant = w_tail_flag;
            end
            default: begin
                w_status = ST_DONE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= w_status;
            r_rslot  <= w_rslot;
            r_grant  <= w_grant;
        end
    end

    assign o_stat.clear_last = r_clr_addr == LOCK_W'(LOCK_COUNT - 1);
    assign o_stat.tail_stale = CFG_W'(w_rd_tail) >= w_size7;
    assign o_stat.mod_last   = r_cnt == CNT_W'(1);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_result_slot = r_rslot;
    assign o_granted     = r_grant;

    // A finished reduction leaves the tail below the slot count
    a_mod_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mod_step && o_stat.mod_last) |=> (CFG_W'(r_tail) < w_size7))
        else $error("reduced tail not below slot count");

    // Every executed command leaves a word in the output register
    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("executed command produced no output word");

endmodule

`default_nettype wire

// ===== sv/aqlu_ctrl.sv =====
// Controller of the lock unit: clearing pass and per-command sequencing.
`timescale 1ns / 1ps
`default_nettype none

module aqlu_ctrl import aqlu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire t_dp_status i_stat,
    output t_dp_cmd         o_cmd,
    output logic            o_in_stall
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_MOD,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.tail_stale ? S_MOD : S_EXEC;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State and registered input stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_stall <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;

    // Words are taken only in the idle state
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !r_in_stall) |-> (r_state == S_IDLE))
        else $error("input word accepted outside idle");

    // Execution returns to idle and opens the input
    a_exec_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_state == S_IDLE && !r_in_stall))
        else $error("no return to idle after execution");

    // Input stays closed during the clearing pass
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> r_in_stall)
        else $error("input open during clearing pass");

endmodule

`default_nettype wire

// ===== tb/tb_array_queue_lock_unit.sv =====
// Self-checking testbench for the array queue lock unit.
`timescale 1ns / 1ps

module tb_array_queue_lock_unit;
    import aqlu_pkg::*;

    localparam int LOCK_COUNT  = 16;
    localparam int MAX_SLOTS   = 64;
    localparam int WATCHDOG    = 5000;
    localparam int DRAIN_WAIT  = 40;
    localparam int PHASE_WORDS = 250;
    localparam int NUM_PHASES  = 8;

    // Command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    typedef struct packed {
        t_status                status;
        logic [SLOT_IO_W-1:0]   rslot;
        logic                   granted;
    } t_lock_resp;

    // Directed row: slot count to run under, command word, typed-in answer if any
    typedef struct packed {
        logic [CFG_W-1:0]       slots;
        logic [CMD_W-1:0]       cmd;
        logic [LOCK_ID_W-1:0]   lock;
        logic [SLOT_IO_W-1:0]   slot;
        logic                   typed;
        t_lock_resp             resp;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata   = '0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_stall;
    logic [CMD_W-1:0]       i_command     = '0;
    logic [LOCK_ID_W-1:0]   i_lock_id     = '0;
    logic [SLOT_IO_W-1:0]   i_slot        = '0;
    logic                   o_out_valid;
    logic                   i_out_stall   = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic [SLOT_IO_W-1:0]   o_result_slot;
    logic                   o_granted;

    // Mirror of the lock bank
    logic [CFG_W-1:0]       slots_cfg = 7'd64;
    logic [SLOT_IO_W-1:0]   lock_tail  [LOCK_COUNT];
    logic [63:0]            lock_flags [LOCK_COUNT];

    t_lock_resp pending_resp [$];
    int         fail_count  = 0;
    int         idle_pct    = 0;
    int         stall_pct   = 0;
    int         quiet_count = 0;

    t_dir_row dir_rows [0:23] = '{
        // reset state, size 64
        '{7'd64,  CMD_QUERY,   4'd0,  6'd0,  1'b1, '{ST_DONE,  6'd0,  1'b1}},
        '{7'd64,  CMD_ACQUIRE, 4'd0,  6'd0,  1'b1, '{ST_DONE,  6'd0,  1'b1}},
        '{7'd64,  CMD_ACQUIRE, 4'd0,  6'd0,  1'b1, '{ST_DONE,  6'd1,  1'b0}},
        '{7'd64,  CMD_TRY,     4'd0,  6'd0,  1'b1, '{ST_BUSY,  6'd0,  1'b0}},
        '{7'd64,  CMD_POLL,    4'd0,  6'd1,  1'b1, '{ST_DONE,  6'd1,  1'b0}},
        '{7'd64,  CMD_RELEASE, 4'd0,  6'd0,  1'b1, '{ST_DONE,  6'd1,  1'b1}},
        '{7'd64,  CMD_POLL,    4'd0,  6'd1,  1'b1, '{ST_DONE,  6'd1,  1'b1}},
        '{7'd64,  CMD_POLL,    4'd15, 6'd63, 1'b1, '{ST_DONE,  6'd63, 1'b0}},
        // release of the top slot wraps to slot 0
        '{7'd64,  CMD_RELEASE, 4'd15, 6'd63, 1'b1, '{ST_DONE,  6'd0,  1'b1}},
        '{7'd64,  CMD_RSVD5,   4'd15, 6'd63, 1'b1, '{ST_DONE,  6'd0,  1'b0}},
        '{7'd64,  CMD_RSVD7,   4'd0,  6'd0,  1'b1, '{ST_DONE,  6'd0,  1'b0}},
        // three slots: out-of-range slots and a release that wraps
        '{7'd3,   CMD_ACQUIRE, 4'd0,  6'd0,  1'b0, '{ST_DONE,  6'd0,  1'b0}},
        '{7'd3,   CMD_POLL,    4'd0,  6'd3,  1'b1, '{ST_RANGE, 6'd0,  1'b0}},
        '{7'd3,   CMD_RELEASE, 4'd0,  6'd63, 1'b1, '{ST_RANGE, 6'd0,  1'b0}},
        '{7'd3,   CMD_RELEASE, 4'd0,  6'd2,  1'b0, '{ST_DONE,  6'd0,  1'b0}},
        // zero slots acts as one
        '{7'd0,   CMD_QUERY,   4'd0,  6'd0,  1'b0, '{ST_DONE,  6'd0,  1'b0}},
        '{7'd0,   CMD_RELEASE, 4'd0,  6'd0,  1'b0, '{ST_DONE,  6'd0,  1'b0}},
        '{7'd0,   CMD_TRY,     4'd0,  6'd0,  1'b0, '{ST_DONE,  6'd0,  1'b0}},
        '{7'd0,   CMD_POLL,    4'd0,  6'd1,  1'b1, '{ST_RANGE, 6'd0,  1'b0}},
        // oversize count acts as 64; build a tail that later goes stale
        '{7'd127, CMD_ACQUIRE, 4'd15, 6'd0,  1'b0, '{ST_DONE,  6'd0,  1'b0}},
        '{7'd127, CMD_ACQUIRE, 4'd15, 6'd0,  1'b0, '{ST_DONE,  6'd0,  1'b0}},
        '{7'd127, CMD_ACQUIRE, 4'd15, 6'd0,  1'b0, '{ST_DONE,  6'd0,  1'b0}},
        // shrink below the stored tail
        '{7'd2,   CMD_QUERY,   4'd15, 6'd0,  1'b0, '{ST_DONE,  6'd0,  1'b0}},
        '{7'd2,   CMD_TRY,     4'd15, 6'd0,  1'b0, '{ST_DONE,  6'd0,  1'b0}}
    };

    array_queue_lock_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_lock_id     (i_lock_id),
        .i_slot        (i_slot),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_result_slot (o_result_slot),
        .o_granted     (o_granted)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Effective slot count, clamped to 1..MAX_SLOTS
    function automatic int active_slots();
        if (slots_cfg == 0) return 1;
        if (int'(slots_cfg) > MAX_SLOTS) return MAX_SLOTS;
        return int'(slots_cfg);
    endfunction

    // One read-modify-write of a lock entry in the mirror
    task automatic step_lock_bank(input logic [CMD_W-1:0] cmd,
                                  input logic [LOCK_ID_W-1:0] id,
                                  input logic [SLOT_IO_W-1:0] s,
                                  output t_lock_resp r);
        int          size;
        int          tail;
        int          nxt;
        logic [63:0] fl;
        size = active_slots();
        tail = int'(lock_tail[id]) % size;
        fl   = lock_flags[id];
        r    = '{ST_DONE, 6'd0, 1'b0};
        case (cmd)
            CMD_ACQUIRE: begin
                r.rslot       = 6'(tail);
                r.granted     = fl[tail];
                lock_tail[id] = 6'((tail + 1) % size);
            end
            CMD_TRY: begin
                if (fl[tail]) begin
                    r.rslot       = 6'(tail);
                    r.granted     = 1'b1;
                    lock_tail[id] = 6'((tail + 1) % size);
                end else begin
                    r.status = ST_BUSY;
                end
            end
            CMD_RELEASE: begin
                if (int'(s) >= size) begin
                    r.status = ST_RANGE;
                end else begin
                    nxt            = (int'(s) + 1) % size;
                    fl[s]          = 1'b0;
                    fl[nxt]        = 1'b1;
                    lock_flags[id] = fl;
                    r.rslot        = 6'(nxt);
                    r.granted      = 1'b1;
                end
            end
            CMD_POLL: begin
                if (int'(s) >= size) begin
                    r.status = ST_RANGE;
                end else begin
                    r.rslot   = s;
                    r.granted = fl[s];
                end
            end
            CMD_QUERY: begin
                r.rslot   = 6'(tail);
                r.granted = fl[tail];
            end
            default: ;
        endcase
    endtask

    // Present one command word, wait for it to be taken, log the expected answer.
    // Called in the time step of the previous acceptance so valid never toggles twice.
    task automatic issue_word(input logic [CMD_W-1:0] cmd, input logic [LOCK_ID_W-1:0] id,
                              input logic [SLOT_IO_W-1:0] s, input logic typed,
                              input t_lock_resp known);
        t_lock_resp predicted;
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_lock_id  <= id;
        i_slot     <= s;
        do @(posedge i_clk); while (o_in_stall);
        step_lock_bank(cmd, id, s, predicted);
        pending_resp.push_back(typed ? known : predicted);
    endtask

    // Hold off the sender until every outstanding answer is back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
    endtask

    // Slot count update, only with the unit idle
    task automatic set_slot_count(input logic [CFG_W-1:0] value);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        slots_cfg   = value;
    endtask

    // Random command word: mostly lock protocol traffic on a few hot locks,
    // the rest noise and out-of-range slots
    task automatic pick_word(output logic [CMD_W-1:0] cmd, output logic [LOCK_ID_W-1:0] id,
                             output logic [SLOT_IO_W-1:0] s);
        int size;
        int pick;
        int start;
        int k;
        size = active_slots();
        pick = $urandom_range(99);
        id   = ($urandom_range(3) != 0) ? 4'($urandom_range(3)) : 4'($urandom);
        s    = 6'($urandom_range(size - 1));
        cmd  = CMD_QUERY;
        if (pick < 8) begin
            cmd = 3'($urandom_range(7));
            s   = 6'($urandom);
        end else if (pick < 38) begin
            cmd = CMD_ACQUIRE;
        end else if (pick < 53) begin
            cmd = CMD_TRY;
        end else if (pick < 75) begin
            // release by the current holder when there is one
            cmd   = CMD_RELEASE;
            start = $urandom_range(size - 1);
            for (k = 0; k < size; k++) begin
                if (lock_flags[id][(start + k) % size]) begin
                    s = 6'((start + k) % size);
                    break;
                end
            end
        end else if (pick < 88) begin
            cmd = CMD_POLL;
        end else if (pick < 96) begin
            cmd = CMD_QUERY;
        end else begin
            cmd = ($urandom_range(1) != 0) ? CMD_RELEASE : CMD_POLL;
            if (size < MAX_SLOTS) s = 6'($urandom_range(MAX_SLOTS - 1, size));
        end
    endtask

    // Answer checker and receiver stall
    always @(posedge i_clk) begin
        t_lock_resp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_resp.size() == 0) begin
                $error("unexpected answer word: status %0d slot %0d granted %0d",
                       o_status, o_result_slot, o_granted);
                fail_count++;
            end else begin
                want = pending_resp.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_result_slot !== want.rslot) begin
                    $error("result_slot: expected %0d, got %0d", want.rslot, o_result_slot);
                    fail_count++;
                end
                if (o_granted !== want.granted) begin
                    $error("granted: expected %0d, got %0d", want.granted, o_granted);
                    fail_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
        end
        if (quiet_count >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Main sequence
    initial begin
        logic [CMD_W-1:0]     cmd;
        logic [LOCK_ID_W-1:0] id;
        logic [SLOT_IO_W-1:0] s;
        logic [CFG_W-1:0]     phase_cfg [NUM_PHASES];
        int                   prof;

        for (int n = 0; n < LOCK_COUNT; n++) begin
            lock_tail[n]  = '0;
            lock_flags[n] = 64'd1;
        end
        phase_cfg = '{7'd1, 7'd64, 7'd2, 7'd127, 7'd0, 7'd65, 7'd7,
                      7'($urandom_range(MAX_SLOTS, 1))};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows, no idling
        foreach (dir_rows[n]) begin
            if (dir_rows[n].slots != slots_cfg) set_slot_count(dir_rows[n].slots);
            issue_word(dir_rows[n].cmd, dir_rows[n].lock, dir_rows[n].slot,
                       dir_rows[n].typed, dir_rows[n].resp);
        end

        // Random phases, each with its own slot count and idle profile
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_slot_count(phase_cfg[p]);
            prof = p % 4;
            idle_pct  = (prof == 1) ? 72 : (prof == 3) ? 10 : 0;
            stall_pct = (prof == 2) ? 72 : (prof == 3) ? 10 : 0;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n == PHASE_WORDS / 2) wait_for_results();
                pick_word(cmd, id, s);
                issue_word(cmd, id, s, 1'b0, '{ST_DONE, 6'd0, 1'b0});
            end
        end

        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
